/* sv/bclru_pkg.sv */
// Shared types and constants of the buffer cache LRU directory.
package bclru_pkg;

    localparam int MODE_W    = 2;
    localparam int BLK_W     = 16;
    localparam int TAG_W     = 13;
    localparam int STATUS_W  = 2;
    localparam int OUT_IDX_W = 5;

    typedef enum logic [MODE_W-1:0] {
        MODE_ALLOC      = 2'd0,
        MODE_LOOKUP     = 2'd1,
        MODE_MARK_DIRTY = 2'd2,
        MODE_FLUSH      = 2'd3
    } mode_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK           = 2'd0,
        STATUS_OUT_OF_BOUND = 2'd1,
        STATUS_NOT_FOUND    = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE      = 3'd0,
        ST_SCAN      = 3'd1,
        ST_FINISH    = 3'd2,
        ST_EMIT      = 3'd3,
        ST_FLUSH_END = 3'd4
    } state_t;

endpackage

/* sv/bclru_if.sv */
// Request and response channel interfaces of the buffer cache LRU directory.
interface bclru_req_if;
    logic                                valid;
    logic                                ready;
    logic [bclru_pkg::MODE_W-1:0]        mode;
    logic signed [bclru_pkg::BLK_W-1:0]  block_num;

    modport source (output valid, output mode, output block_num, input ready);
    modport sink (input valid, input mode, input block_num, output ready);
endinterface

interface bclru_rsp_if;
    logic                              valid;
    logic                              ready;
    logic [bclru_pkg::STATUS_W-1:0]    status;
    logic [bclru_pkg::OUT_IDX_W-1:0]   buffer_index;
    logic                              writeback_valid;
    logic [bclru_pkg::TAG_W-1:0]       writeback_block;
    logic                              last;

    modport source (output valid, output status, output buffer_index,
                    output writeback_valid, output writeback_block, output last,
                    input ready);
    modport sink (input valid, input status, input buffer_index,
                  input writeback_valid, input writeback_block, input last,
                  output ready);
endinterface

/* sv/bclru_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
module bclru_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* sv/buffer_cache_lru_table_core.sv */
// Top level of the buffer cache LRU directory: sequencer over one entry scan.
//
//  channel | dir | handshake    | payload
//  --------+-----+--------------+--------------------------------------------------
//  req     | in  | valid/ready  | mode, block_num
//  rsp     | out | valid/ready  | status, buffer_index, writeback_valid,
//          |     |              | writeback_block, last
//
// One entry is visited per cycle through the tag and age RAM read ports, unless
// a flush holds the scan on a stalled response. Allocate: scan, commit, emit.
// Lookup / mark dirty: scan, ending early on a hit, then emit; out of bound goes
// straight to emit. Flush: scan, then a final response; response stalls hold the scan.
// Reset clears the occupancy and dirty flags at once; no clearing pass.
// A stalled response holds the scan only in flush; req is ready in idle only.
module buffer_cache_lru_table_core #(
    parameter int ENTRIES          = 32,
    parameter int DISK_BLOCK_COUNT = 8192,
    parameter int AGE_BITS         = 16
) (
    input logic        clk,
    input logic        rst_n,
    bclru_req_if.sink  req,
    bclru_rsp_if.source rsp
);

    localparam int IDX_W = $clog2(ENTRIES);
    localparam int EXT_W = IDX_W + bclru_pkg::OUT_IDX_W;
    localparam int PAD_W = bclru_pkg::BLK_W - bclru_pkg::TAG_W;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);
    localparam logic [bclru_pkg::BLK_W-1:0] BLK_LIMIT = bclru_pkg::BLK_W'(DISK_BLOCK_COUNT);

    bclru_pkg::state_t state_reg, state_next;
    bclru_pkg::mode_t  mode_reg, mode_next;
    logic [bclru_pkg::BLK_W-1:0] blk_reg, blk_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             free_found_reg, free_found_next;
    logic [IDX_W-1:0] free_idx_reg, free_idx_next;
    logic [IDX_W-1:0] best_idx_reg, best_idx_next;
    logic [AGE_BITS-1:0] best_age_reg, best_age_next;
    logic [bclru_pkg::TAG_W-1:0] best_tag_reg, best_tag_next;
    logic             pend_valid_reg, pend_valid_next;
    logic [IDX_W-1:0] pend_idx_reg, pend_idx_next;
    logic [bclru_pkg::TAG_W-1:0] pend_tag_reg, pend_tag_next;
    bclru_pkg::status_t res_status_reg, res_status_next;
    logic [IDX_W-1:0] res_idx_reg, res_idx_next;
    logic             res_wb_valid_reg, res_wb_valid_next;
    logic [bclru_pkg::TAG_W-1:0] res_wb_block_reg, res_wb_block_next;
    logic [ENTRIES-1:0] occupied_reg, occupied_next;
    logic [ENTRIES-1:0] dirty_reg, dirty_next;

    logic             out_valid_reg, out_valid_next;
    bclru_pkg::status_t out_status_reg, out_status_next;
    logic [IDX_W-1:0] out_idx_reg, out_idx_next;
    logic             out_wb_valid_reg, out_wb_valid_next;
    logic [bclru_pkg::TAG_W-1:0] out_wb_block_reg, out_wb_block_next;
    logic             out_last_reg, out_last_next;

    logic [IDX_W-1:0]            rd_addr;
    logic                        age_we;
    logic [IDX_W-1:0]            age_waddr;
    logic [AGE_BITS-1:0]         age_wdata;
    logic [AGE_BITS-1:0]         age_rdata;
    logic                        tag_we;
    logic [bclru_pkg::TAG_W-1:0] tag_rdata;

    logic                        out_free;
    logic                        scan_last;
    logic [IDX_W-1:0]            idx_inc;
    logic                        occ_cur;
    logic                        dirty_cur;
    logic [AGE_BITS-1:0]         age_inc;
    logic                        tag_match;
    logic [IDX_W-1:0]            victim;
    logic                        in_bound;
    logic [bclru_pkg::BLK_W-1:0] req_blk;
    logic [EXT_W-1:0]            out_idx_ext;

    bclru_ram #(
        .WIDTH (AGE_BITS),
        .DEPTH (ENTRIES)
    ) u_age_ram (
        .clk   (clk),
        .we    (age_we),
        .waddr (age_waddr),
        .wdata (age_wdata),
        .raddr (rd_addr),
        .rdata (age_rdata)
    );

    bclru_ram #(
        .WIDTH (bclru_pkg::TAG_W),
        .DEPTH (ENTRIES)
    ) u_tag_ram (
        .clk   (clk),
        .we    (tag_we),
        .waddr (victim),
        .wdata (blk_reg[bclru_pkg::TAG_W-1:0]),
        .raddr (rd_addr),
        .rdata (tag_rdata)
    );

    assign out_free  = !out_valid_reg || rsp.ready;
    assign scan_last = (idx_reg == LAST_IDX);
    assign idx_inc   = scan_last ? '0 : idx_reg + 1'b1;
    assign occ_cur   = occupied_reg[idx_reg];
    assign dirty_cur = dirty_reg[idx_reg];
    assign age_inc   = (&age_rdata) ? age_rdata : age_rdata + 1'b1;
    assign tag_match = occ_cur && (blk_reg == {{PAD_W{1'b0}}, tag_rdata});
    assign victim    = free_found_reg ? free_idx_reg : best_idx_reg;
    assign req_blk   = req.block_num;
    assign in_bound  = !req_blk[bclru_pkg::BLK_W-1] && (req_blk < BLK_LIMIT);

    assign req.ready           = (state_reg == bclru_pkg::ST_IDLE);
    assign out_idx_ext         = EXT_W'(out_idx_reg);
    assign rsp.valid           = out_valid_reg;
    assign rsp.status          = out_status_reg;
    assign rsp.buffer_index    = out_idx_ext[bclru_pkg::OUT_IDX_W-1:0];
    assign rsp.writeback_valid = out_wb_valid_reg;
    assign rsp.writeback_block = out_wb_block_reg;
    assign rsp.last            = out_last_reg;

    always_comb
    begin
        state_next        = state_reg;
        mode_next         = mode_reg;
        blk_next          = blk_reg;
        idx_next          = idx_reg;
        free_found_next   = free_found_reg;
        free_idx_next     = free_idx_reg;
        best_idx_next     = best_idx_reg;
        best_age_next     = best_age_reg;
        best_tag_next     = best_tag_reg;
        pend_valid_next   = pend_valid_reg;
        pend_idx_next     = pend_idx_reg;
        pend_tag_next     = pend_tag_reg;
        res_status_next   = res_status_reg;
        res_idx_next      = res_idx_reg;
        res_wb_valid_next = res_wb_valid_reg;
        res_wb_block_next = res_wb_block_reg;
        occupied_next     = occupied_reg;
        dirty_next        = dirty_reg;

        out_valid_next    = out_valid_reg && !rsp.ready;
        out_status_next   = out_status_reg;
        out_idx_next      = out_idx_reg;
        out_wb_valid_next = out_wb_valid_reg;
        out_wb_block_next = out_wb_block_reg;
        out_last_next     = out_last_reg;

        rd_addr   = '0;
        age_we    = 1'b0;
        age_waddr = idx_reg;
        age_wdata = age_inc;
        tag_we    = 1'b0;

        unique case (state_reg)
            bclru_pkg::ST_IDLE:
            begin
                if (req.valid)
                begin
                    mode_next       = bclru_pkg::mode_t'(req.mode);
                    blk_next        = req_blk;
                    idx_next        = '0;
                    free_found_next = 1'b0;
                    free_idx_next   = '0;
                    best_idx_next   = '0;
                    best_age_next   = '0;
                    best_tag_next   = '0;
                    pend_valid_next = 1'b0;
                    if (bclru_pkg::mode_t'(req.mode) == bclru_pkg::MODE_FLUSH)
                    begin
                        state_next = bclru_pkg::ST_SCAN;
                    end
                    else if (!in_bound)
                    begin
                        res_status_next   = bclru_pkg::STATUS_OUT_OF_BOUND;
                        res_idx_next      = '0;
                        res_wb_valid_next = 1'b0;
                        res_wb_block_next = '0;
                        state_next        = bclru_pkg::ST_EMIT;
                    end
                    else
                    begin
                        state_next = bclru_pkg::ST_SCAN;
                    end
                end
            end

            bclru_pkg::ST_SCAN:
            begin
                rd_addr = idx_inc;
                unique case (mode_reg)
                    bclru_pkg::MODE_ALLOC:
                    begin
                        // age occupied entries, track first free and oldest
                        age_we = occ_cur;
                        if (!occ_cur && !free_found_reg)
                        begin
                            free_found_next = 1'b1;
                            free_idx_next   = idx_reg;
                        end
                        if ((occ_cur ? age_inc : age_rdata) > best_age_reg)
                        begin
                            best_age_next = occ_cur ? age_inc : age_rdata;
                            best_idx_next = idx_reg;
                            best_tag_next = tag_rdata;
                        end
                        idx_next = idx_inc;
                        if (scan_last)
                        begin
                            state_next = bclru_pkg::ST_FINISH;
                        end
                    end

                    bclru_pkg::MODE_LOOKUP, bclru_pkg::MODE_MARK_DIRTY:
                    begin
                        if (tag_match)
                        begin
                            res_status_next   = bclru_pkg::STATUS_OK;
                            res_idx_next      = idx_reg;
                            res_wb_valid_next = 1'b0;
                            res_wb_block_next = '0;
                            if (mode_reg == bclru_pkg::MODE_MARK_DIRTY)
                            begin
                                dirty_next[idx_reg] = 1'b1;
                            end
                            state_next = bclru_pkg::ST_EMIT;
                        end
                        else if (scan_last)
                        begin
                            res_status_next   = bclru_pkg::STATUS_NOT_FOUND;
                            res_idx_next      = '0;
                            res_wb_valid_next = 1'b0;
                            res_wb_block_next = '0;
                            state_next        = bclru_pkg::ST_EMIT;
                        end
                        else
                        begin
                            idx_next = idx_inc;
                        end
                    end

                    bclru_pkg::MODE_FLUSH:
                    begin
                        if (occ_cur && dirty_cur && pend_valid_reg && !out_free)
                        begin
                            // hold this entry until the response register drains
                            rd_addr = idx_reg;
                        end
                        else
                        begin
                            if (occ_cur && dirty_cur)
                            begin
                                if (pend_valid_reg)
                                begin
                                    out_valid_next    = 1'b1;
                                    out_status_next   = bclru_pkg::STATUS_OK;
                                    out_idx_next      = pend_idx_reg;
                                    out_wb_valid_next = 1'b1;
                                    out_wb_block_next = pend_tag_reg;
                                    out_last_next     = 1'b0;
                                end
                                pend_valid_next = 1'b1;
                                pend_idx_next   = idx_reg;
                                pend_tag_next   = tag_rdata;
                            end
                            idx_next = idx_inc;
                            if (scan_last)
                            begin
                                state_next = bclru_pkg::ST_FLUSH_END;
                            end
                        end
                    end
                endcase
            end

            bclru_pkg::ST_FINISH:
            begin
                age_we                = 1'b1;
                age_waddr             = victim;
                age_wdata             = '0;
                tag_we                = 1'b1;
                occupied_next[victim] = 1'b1;
                dirty_next[victim]    = 1'b0;
                res_status_next       = bclru_pkg::STATUS_OK;
                res_idx_next          = victim;
                res_wb_valid_next     = !free_found_reg && dirty_reg[best_idx_reg];
                res_wb_block_next     = (!free_found_reg && dirty_reg[best_idx_reg])
                                        ? best_tag_reg : '0;
                state_next            = bclru_pkg::ST_EMIT;
            end

            bclru_pkg::ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next    = 1'b1;
                    out_status_next   = res_status_reg;
                    out_idx_next      = res_idx_reg;
                    out_wb_valid_next = res_wb_valid_reg;
                    out_wb_block_next = res_wb_block_reg;
                    out_last_next     = 1'b1;
                    state_next        = bclru_pkg::ST_IDLE;
                end
            end

            bclru_pkg::ST_FLUSH_END:
            begin
                if (out_free)
                begin
                    out_valid_next    = 1'b1;
                    out_status_next   = bclru_pkg::STATUS_OK;
                    out_idx_next      = pend_valid_reg ? pend_idx_reg : '0;
                    out_wb_valid_next = pend_valid_reg;
                    out_wb_block_next = pend_valid_reg ? pend_tag_reg : '0;
                    out_last_next     = 1'b1;
                    pend_valid_next   = 1'b0;
                    dirty_next        = '0;
                    state_next        = bclru_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = bclru_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= bclru_pkg::ST_IDLE;
            mode_reg         <= bclru_pkg::MODE_ALLOC;
            blk_reg          <= '0;
            idx_reg          <= '0;
            free_found_reg   <= 1'b0;
            free_idx_reg     <= '0;
            best_idx_reg     <= '0;
            best_age_reg     <= '0;
            best_tag_reg     <= '0;
            pend_valid_reg   <= 1'b0;
            pend_idx_reg     <= '0;
            pend_tag_reg     <= '0;
            res_status_reg   <= bclru_pkg::STATUS_OK;
            res_idx_reg      <= '0;
            res_wb_valid_reg <= 1'b0;
            res_wb_block_reg <= '0;
            occupied_reg     <= '0;
            dirty_reg        <= '0;
            out_valid_reg    <= 1'b0;
            out_status_reg   <= bclru_pkg::STATUS_OK;
            out_idx_reg      <= '0;
            out_wb_valid_reg <= 1'b0;
            out_wb_block_reg <= '0;
            out_last_reg     <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            mode_reg         <= mode_next;
            blk_reg          <= blk_next;
            idx_reg          <= idx_next;
            free_found_reg   <= free_found_next;
            free_idx_reg     <= free_idx_next;
            best_idx_reg     <= best_idx_next;
            best_age_reg     <= best_age_next;
            best_tag_reg     <= best_tag_next;
            pend_valid_reg   <= pend_valid_next;
            pend_idx_reg     <= pend_idx_next;
            pend_tag_reg     <= pend_tag_next;
            res_status_reg   <= res_status_next;
            res_idx_reg      <= res_idx_next;
            res_wb_valid_reg <= res_wb_valid_next;
            res_wb_block_reg <= res_wb_block_next;
            occupied_reg     <= occupied_next;
            dirty_reg        <= dirty_next;
            out_valid_reg    <= out_valid_next;
            out_status_reg   <= out_status_next;
            out_idx_reg      <= out_idx_next;
            out_wb_valid_reg <= out_wb_valid_next;
            out_wb_block_reg <= out_wb_block_next;
            out_last_reg     <= out_last_next;
        end
    end

`ifndef ASSERT_OFF
    a_oob_single: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.status == bclru_pkg::STATUS_OUT_OF_BOUND
        |-> rsp.last && !rsp.writeback_valid && rsp.buffer_index == '0)
        else $error("out-of-bound response carries entry data");

    a_wb_success: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.writeback_valid |-> rsp.status == bclru_pkg::STATUS_OK)
        else $error("writeback requested on a failed request");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        req.valid && req.ready |=> !req.ready)
        else $error("request taken while a transaction is in progress");

    a_pend_in_flush: assert property (@(posedge clk) disable iff (!rst_n)
        pend_valid_reg |-> mode_reg == bclru_pkg::MODE_FLUSH
            && (state_reg == bclru_pkg::ST_SCAN || state_reg == bclru_pkg::ST_FLUSH_END))
        else $error("pending writeback outside a flush");
`endif

endmodule

/* tb/sv/tb_top.sv */
// Self-checking testbench of the buffer cache LRU directory core.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import bclru_pkg::*;

    localparam int ENTRIES          = 32;
    localparam int DISK_BLOCK_COUNT = 8192;
    localparam int AGE_BITS         = 16;
    localparam int RAND_ITEMS       = 410;
    localparam int CALM_TAIL        = 60;
    localparam int LONG_HOLD        = 300;
    localparam int POOL_DEPTH       = 40;

    typedef struct packed {
        status_t              status;
        logic [OUT_IDX_W-1:0] buffer_index;
        logic                 wb_valid;
        logic [TAG_W-1:0]     wb_block;
        logic                 last;
    } dir_rsp_t;

    typedef struct {
        mode_t                   mode;
        logic signed [BLK_W-1:0] blk;
        bit                      typed;
        dir_rsp_t                want;
    } stim_row_t;

    logic clk;
    logic rst_n;

    bclru_req_if req_bus();
    bclru_rsp_if rsp_bus();

    buffer_cache_lru_table_core #(
        .ENTRIES          (ENTRIES),
        .DISK_BLOCK_COUNT (DISK_BLOCK_COUNT),
        .AGE_BITS         (AGE_BITS)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_bus),
        .rsp   (rsp_bus)
    );

    // Directory shadow
    bit                  occ_tab   [ENTRIES];
    bit                  dirty_tab [ENTRIES];
    logic [AGE_BITS-1:0] age_tab   [ENTRIES];
    logic [TAG_W-1:0]    tag_tab   [ENTRIES];

    dir_rsp_t  new_rsp_q[$];
    dir_rsp_t  pending_rsp_q[$];
    stim_row_t stim_rows[$];
    int        held_pool[$];

    int  mismatches;
    int  rsp_checked;
    int  mode_cnt[4];
    int  evict_cnt;
    int  dirty_evict_cnt;
    int  flush_wb_cnt;
    int  oob_cnt;
    bit  idle_on;
    bit  long_hold_req;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    initial begin
        #10_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    function automatic dir_rsp_t mk_rsp(status_t s, int idx, bit wbv, int wbb, bit lst);
        dir_rsp_t r;
        r.status       = s;
        r.buffer_index = OUT_IDX_W'(idx);
        r.wb_valid     = wbv;
        r.wb_block     = TAG_W'(wbb);
        r.last         = lst;
        return r;
    endfunction

    // Apply one request to the shadow directory and fill new_rsp_q with its responses.
    function automatic void model_directory(mode_t m, logic signed [BLK_W-1:0] blk);
        int  chosen;
        int  hit;
        bit  in_range;
        logic [AGE_BITS-1:0] best;
        new_rsp_q.delete();
        in_range = (blk >= 0) && (blk < DISK_BLOCK_COUNT);
        if (m == MODE_FLUSH) begin
            for (int i = 0; i < ENTRIES; i++) begin
                if (occ_tab[i] && dirty_tab[i]) begin
                    new_rsp_q.push_back(mk_rsp(STATUS_OK, i, 1'b1, tag_tab[i], 1'b0));
                    flush_wb_cnt++;
                end
                dirty_tab[i] = 1'b0;
            end
            if (new_rsp_q.size() == 0)
                new_rsp_q.push_back(mk_rsp(STATUS_OK, 0, 1'b0, 0, 1'b1));
            else
                new_rsp_q[new_rsp_q.size()-1].last = 1'b1;
        end else if (!in_range) begin
            new_rsp_q.push_back(mk_rsp(STATUS_OUT_OF_BOUND, 0, 1'b0, 0, 1'b1));
            oob_cnt++;
        end else if (m == MODE_ALLOC) begin
            chosen = -1;
            for (int i = 0; i < ENTRIES; i++)
                if (occ_tab[i] && age_tab[i] != {AGE_BITS{1'b1}})
                    age_tab[i] = age_tab[i] + 1'b1;
            for (int i = 0; i < ENTRIES && chosen < 0; i++)
                if (!occ_tab[i])
                    chosen = i;
            if (chosen < 0) begin
                // Evict the oldest; strict compare keeps the lowest index on a tie
                best   = '0;
                chosen = 0;
                for (int i = 0; i < ENTRIES; i++) begin
                    if (age_tab[i] > best) begin
                        best   = age_tab[i];
                        chosen = i;
                    end
                end
                evict_cnt++;
                if (dirty_tab[chosen]) dirty_evict_cnt++;
                new_rsp_q.push_back(mk_rsp(STATUS_OK, chosen, dirty_tab[chosen],
                                           dirty_tab[chosen] ? tag_tab[chosen] : 0, 1'b1));
            end else begin
                new_rsp_q.push_back(mk_rsp(STATUS_OK, chosen, 1'b0, 0, 1'b1));
            end
            occ_tab[chosen]   = 1'b1;
            dirty_tab[chosen] = 1'b0;
            age_tab[chosen]   = '0;
            tag_tab[chosen]   = blk[TAG_W-1:0];
        end else begin
            hit = -1;
            for (int i = 0; i < ENTRIES && hit < 0; i++)
                if (occ_tab[i] && tag_tab[i] == blk[TAG_W-1:0])
                    hit = i;
            if (hit < 0) begin
                new_rsp_q.push_back(mk_rsp(STATUS_NOT_FOUND, 0, 1'b0, 0, 1'b1));
            end else begin
                if (m == MODE_MARK_DIRTY) dirty_tab[hit] = 1'b1;
                new_rsp_q.push_back(mk_rsp(STATUS_OK, hit, 1'b0, 0, 1'b1));
            end
        end
    endfunction

    // Offer one request, hold it until it is accepted, then record expectations.
    task automatic issue_request(mode_t m, logic signed [BLK_W-1:0] blk, bit typed,
                                 dir_rsp_t want);
        req_bus.valid     <= 1'b1;
        req_bus.mode      <= m;
        req_bus.block_num <= blk;
        do @(posedge clk); while (!req_bus.ready);
        model_directory(m, blk);
        if (typed)
            pending_rsp_q.push_back(want);
        else
            foreach (new_rsp_q[i]) pending_rsp_q.push_back(new_rsp_q[i]);
        if (m == MODE_ALLOC && blk >= 0 && blk < DISK_BLOCK_COUNT) begin
            held_pool.push_back(int'(blk));
            if (held_pool.size() > POOL_DEPTH) void'(held_pool.pop_front());
        end
        mode_cnt[m]++;
    endtask

    task automatic add_row(mode_t m, logic signed [BLK_W-1:0] blk, bit typed, dir_rsp_t want);
        stim_row_t row;
        row.mode  = m;
        row.blk   = blk;
        row.typed = typed;
        row.want  = want;
        stim_rows.push_back(row);
    endtask

    function automatic logic signed [BLK_W-1:0] out_of_range_block();
        if ($urandom_range(0, 1) == 0)
            return {1'b1, 15'($urandom)};
        return BLK_W'($urandom_range(DISK_BLOCK_COUNT, 32767));
    endfunction

    function automatic logic signed [BLK_W-1:0] pool_block();
        if (held_pool.size() == 0)
            return BLK_W'($urandom_range(0, DISK_BLOCK_COUNT - 1));
        return BLK_W'(held_pool[$urandom_range(0, held_pool.size() - 1)]);
    endfunction

    // Response ready: random stall bursts, plus one long hold-off on request
    initial begin
        int hold_left;
        hold_left     = 0;
        rsp_bus.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever begin
            @(posedge clk);
            if (hold_left > 0) begin
                rsp_bus.ready <= 1'b0;
                hold_left--;
            end else if (long_hold_req) begin
                long_hold_req = 1'b0;
                hold_left     = LONG_HOLD - 1;
                rsp_bus.ready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 7) == 0) begin
                hold_left     = $urandom_range(0, 14);
                rsp_bus.ready <= 1'b0;
            end else begin
                rsp_bus.ready <= 1'b1;
            end
        end
    end

    always @(posedge clk) begin : check_rsp
        dir_rsp_t want;
        if (rst_n && rsp_bus.valid && rsp_bus.ready) begin
            rsp_checked++;
            if (pending_rsp_q.size() == 0) begin
                $error("unexpected response: status %0d index %0d wb %0d/%0d last %0d",
                       rsp_bus.status, rsp_bus.buffer_index, rsp_bus.writeback_valid,
                       rsp_bus.writeback_block, rsp_bus.last);
                mismatches++;
            end else begin
                want = pending_rsp_q.pop_front();
                if (rsp_bus.status !== want.status) begin
                    $error("status: expected %0d, actual %0d", want.status, rsp_bus.status);
                    mismatches++;
                end
                if (rsp_bus.buffer_index !== want.buffer_index) begin
                    $error("buffer_index: expected %0d, actual %0d",
                           want.buffer_index, rsp_bus.buffer_index);
                    mismatches++;
                end
                if (rsp_bus.writeback_valid !== want.wb_valid) begin
                    $error("writeback_valid: expected %0d, actual %0d",
                           want.wb_valid, rsp_bus.writeback_valid);
                    mismatches++;
                end
                if (rsp_bus.writeback_block !== want.wb_block) begin
                    $error("writeback_block: expected %0d, actual %0d",
                           want.wb_block, rsp_bus.writeback_block);
                    mismatches++;
                end
                if (rsp_bus.last !== want.last) begin
                    $error("last: expected %0d, actual %0d", want.last, rsp_bus.last);
                    mismatches++;
                end
            end
        end
    end

    initial begin
        dir_rsp_t                none;
        dir_rsp_t                oob;
        dir_rsp_t                miss;
        mode_t                   m;
        logic signed [BLK_W-1:0] blk;
        int                      r;
        int                      gap;

        none = mk_rsp(STATUS_OK, 0, 1'b0, 0, 1'b1);
        oob  = mk_rsp(STATUS_OUT_OF_BOUND, 0, 1'b0, 0, 1'b1);
        miss = mk_rsp(STATUS_NOT_FOUND, 0, 1'b0, 0, 1'b1);

        rst_n             <= 1'b0;
        req_bus.valid     <= 1'b0;
        req_bus.mode      <= MODE_ALLOC;
        req_bus.block_num <= '0;
        idle_on           = 1'b1;
        long_hold_req     = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        add_row(MODE_LOOKUP,     16'sd0,      1'b1, miss);
        add_row(MODE_FLUSH,      16'sd0,      1'b1, none);
        add_row(MODE_ALLOC,      -16'sd32768, 1'b1, oob);
        add_row(MODE_ALLOC,      16'sd8192,   1'b1, oob);
        add_row(MODE_LOOKUP,     -16'sd1,     1'b1, oob);
        add_row(MODE_ALLOC,      16'sd8191,   1'b1, mk_rsp(STATUS_OK, 0, 1'b0, 0, 1'b1));
        add_row(MODE_ALLOC,      16'sd0,      1'b1, mk_rsp(STATUS_OK, 1, 1'b0, 0, 1'b1));
        add_row(MODE_LOOKUP,     16'sd8191,   1'b1, mk_rsp(STATUS_OK, 0, 1'b0, 0, 1'b1));
        add_row(MODE_MARK_DIRTY, 16'sd0,      1'b1, mk_rsp(STATUS_OK, 1, 1'b0, 0, 1'b1));
        add_row(MODE_MARK_DIRTY, 16'sd32767,  1'b1, oob);
        add_row(MODE_MARK_DIRTY, 16'sd5,      1'b1, miss);
        // Duplicate allocate takes a fresh entry; lookup still finds the lowest one
        add_row(MODE_ALLOC,      16'sd0,      1'b1, mk_rsp(STATUS_OK, 2, 1'b0, 0, 1'b1));
        add_row(MODE_LOOKUP,     16'sd0,      1'b1, mk_rsp(STATUS_OK, 1, 1'b0, 0, 1'b1));
        add_row(MODE_FLUSH,      16'sh5555,   1'b0, none);
        add_row(MODE_FLUSH,      -16'sd1,     1'b1, none);
        add_row(MODE_MARK_DIRTY, 16'sd8191,   1'b1, mk_rsp(STATUS_OK, 0, 1'b0, 0, 1'b1));
        add_row(MODE_MARK_DIRTY, 16'sd0,      1'b1, mk_rsp(STATUS_OK, 1, 1'b0, 0, 1'b1));
        add_row(MODE_MARK_DIRTY, 16'sd0,      1'b0, none);
        add_row(MODE_FLUSH,      16'sh7FFF,   1'b0, none);
        add_row(MODE_LOOKUP,     16'sd4096,   1'b1, miss);

        foreach (stim_rows[i]) begin
            issue_request(stim_rows[i].mode, stim_rows[i].blk, stim_rows[i].typed,
                          stim_rows[i].want);
            if ($urandom_range(0, 3) == 0) begin
                gap = $urandom_range(1, 15);
                req_bus.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end

        for (int n = 0; n < RAND_ITEMS; n++) begin
            if (n % 40 == 0) idle_on = ($urandom_range(0, 2) != 0);
            if (n >= RAND_ITEMS - CALM_TAIL) idle_on = 1'b0;
            // Stall the response side for a long stretch while requests keep being offered
            if (n == 150) long_hold_req = 1'b1;

            r = $urandom_range(0, 99);
            if (r < 40)      m = MODE_ALLOC;
            else if (r < 67) m = MODE_LOOKUP;
            else if (r < 92) m = MODE_MARK_DIRTY;
            else             m = MODE_FLUSH;

            r = $urandom_range(0, 99);
            if (m == MODE_FLUSH)
                blk = BLK_W'($urandom);
            else if (m == MODE_ALLOC)
                blk = (r < 70) ? BLK_W'($urandom_range(0, DISK_BLOCK_COUNT - 1)) :
                      (r < 82) ? pool_block() :
                      (r < 88) ? ((r % 2) ? BLK_W'(DISK_BLOCK_COUNT - 1) : '0) :
                                 out_of_range_block();
            else
                blk = (r < 70) ? pool_block() :
                      (r < 85) ? BLK_W'($urandom_range(0, DISK_BLOCK_COUNT - 1)) :
                                 out_of_range_block();

            issue_request(m, blk, 1'b0, none);

            if (n == 260) begin
                // Drain every outstanding response before offering more
                req_bus.valid <= 1'b0;
                do @(posedge clk); while (pending_rsp_q.size() != 0);
            end else if (idle_on && $urandom_range(0, 3) == 0) begin
                gap = $urandom_range(1, 15);
                req_bus.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end else if (n == RAND_ITEMS - 1) begin
                req_bus.valid <= 1'b0;
            end
        end

        while (pending_rsp_q.size() != 0) @(posedge clk);
        repeat (ENTRIES + 8) @(posedge clk);

        $display("Run covered %0d allocate, %0d lookup, %0d mark dirty, %0d flush requests; %0d responses checked",
                 mode_cnt[MODE_ALLOC], mode_cnt[MODE_LOOKUP], mode_cnt[MODE_MARK_DIRTY],
                 mode_cnt[MODE_FLUSH], rsp_checked);
        $display("Evictions %0d (%0d dirty), flush writebacks %0d, out-of-bound requests %0d",
                 evict_cnt, dirty_evict_cnt, flush_wb_cnt, oob_cnt);
        if (mismatches == 0 && pending_rsp_q.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

/* files.f */
sv/bclru_pkg.sv
sv/bclru_if.sv
sv/bclru_ram.sv
sv/buffer_cache_lru_table_core.sv
tb/sv/tb_top.sv
